// ===== hdl/rzs_pkg.sv =====
package rzs_pkg;

    // block sizing
    localparam int C_WINDOW    = 8;
    localparam int C_FRAC      = 16;
    localparam int C_PRICE_W   = 32;
    localparam int C_CFG_W     = 24;
    localparam int C_CFG_IDX_W = 8;
    localparam int C_CODE_W    = 3;
    localparam int C_Z_W       = 24;

    // derived widths
    localparam int C_PTR_W  = (C_WINDOW > 1) ? $clog2(C_WINDOW) : 1;
    localparam int C_FILL_W = $clog2(C_WINDOW + 1);
    localparam int C_X_W    = C_PRICE_W + 1;
    localparam int C_MAG_W  = C_X_W;
    localparam int C_MUL_W  = C_MAG_W;
    localparam int C_PROD_W = 2 * C_MUL_W;
    localparam int C_S_W    = C_X_W + C_PTR_W;
    localparam int C_HALF_W = (C_S_W + 1) / 2;
    localparam int C_Q_W    = C_PROD_W + C_PTR_W;
    localparam int C_D_W    = 2 * C_S_W;
    localparam int C_ROOT_W = C_D_W / 2;
    localparam int C_REM_W  = C_ROOT_W + 2;
    localparam int C_NUM_W  = C_S_W + 1;
    localparam int C_DVD_W  = C_NUM_W + C_FRAC + 1;
    localparam int C_CNT_W  = $clog2(C_DVD_W);

    // thresholds after reset: 1.0 and 0.8
    localparam int C_ENTER_RST = 1 << C_FRAC;
    localparam int C_EXIT_RST  = ((8 << C_FRAC) + 5) / 10;

    localparam int C_Z_POS_MAX = (1 << (C_Z_W - 1)) - 1;
    localparam int C_Z_NEG_MAX = 1 << (C_Z_W - 1);

    // register indexes
    localparam logic [C_CFG_IDX_W-1:0] C_REG_ENTER = C_CFG_IDX_W'(0);
    localparam logic [C_CFG_IDX_W-1:0] C_REG_EXIT  = C_CFG_IDX_W'(1);

    // partial products of the squared window sum
    localparam logic [1:0] C_PART_LL = 2'd0;
    localparam logic [1:0] C_PART_HL = 2'd1;
    localparam logic [1:0] C_PART_HH = 2'd2;

    typedef enum logic [C_CODE_W-1:0] {
        SIG_WARM  = 3'd0,
        SIG_ABOVE = 3'd1,
        SIG_BELOW = 3'd2,
        SIG_CLOSE = 3'd3,
        SIG_HOLD  = 3'd4,
        SIG_FLAT  = 3'd5
    } t_sig;

    typedef struct packed {
        logic               capture;
        logic               ring_we;
        logic               rd_en;
        logic [C_PTR_W-1:0] ring_addr;
        logic               acc_clr;
        logic               sq_step;
        logic               acc_step;
        logic               sqr_mul;
        logic               sqr_acc;
        logic [1:0]         part;
        logic               diff;
        logic               root_step;
        logic               div_init;
        logic               div_step;
        logic               out_load;
        logic               warm;
    } t_cmd;

    typedef struct packed {
        logic flat;
    } t_sts;

endpackage

// ===== hdl/rzs_ram.sv =====
module rzs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/rzs_dp.sv =====
module rzs_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rzs_pkg::t_cmd                        i_cmd,
    output rzs_pkg::t_sts                        o_sts,
    input  logic [rzs_pkg::C_PRICE_W-1:0]        i_price_a,
    input  logic [rzs_pkg::C_PRICE_W-1:0]        i_price_b,
    input  logic                                 i_cfg_write,
    input  logic [rzs_pkg::C_CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rzs_pkg::C_CFG_W-1:0]          i_cfg_data,
    output logic [rzs_pkg::C_CODE_W-1:0]         o_signal_code,
    output logic signed [rzs_pkg::C_Z_W-1:0]     o_z_value,
    output logic                                 o_z_saturated
);
    import rzs_pkg::*;

    logic [C_CFG_W-1:0]  r_enter, r_exit;
    logic [C_X_W-1:0]    r_x;
    logic [C_S_W-1:0]    r_s;
    logic [C_Q_W-1:0]    r_q;
    logic [C_PROD_W-1:0] r_prod;
    logic [C_D_W-1:0]    r_s2, r_d;
    logic                r_neg, r_flat;
    logic [C_NUM_W-1:0]  r_nmag;
    logic [C_ROOT_W-1:0] r_root, r_dr;
    logic [C_REM_W-1:0]  r_rem;
    logic [C_DVD_W-1:0]  r_dvd;
    logic [C_CODE_W-1:0] r_code;
    logic [C_Z_W-1:0]    r_z;
    logic                r_zsat;

    logic [C_X_W-1:0]    w_rd;
    logic [C_MAG_W-1:0]  w_rd_mag;
    logic [C_S_W-1:0]    w_smag;
    logic [C_HALF_W-1:0] w_lo, w_hi;
    logic [C_MUL_W-1:0]  w_mul_a, w_mul_b;
    logic [C_PROD_W-1:0] w_prod;
    logic [C_D_W-1:0]    w_part, w_nq, w_d;
    logic [C_NUM_W-1:0]  w_xe, w_se, w_num;
    logic [C_REM_W+1:0]  w_rsh, w_trial, w_rdiff;
    logic                w_rge;
    logic [C_ROOT_W:0]   w_dsh, w_ddiff;
    logic                w_dge;
    logic                w_gt_enter, w_lt_exit, w_pos_sat, w_neg_sat;
    logic [C_CODE_W-1:0] w_code;
    logic [C_Z_W-1:0]    w_z, w_zneg;
    logic                w_zsat;

    rzs_ram #(
        .WIDTH(C_X_W),
        .DEPTH(C_WINDOW)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (i_cmd.ring_we),
        .i_waddr(i_cmd.ring_addr),
        .i_wdata(r_x),
        .i_re   (i_cmd.rd_en),
        .i_raddr(i_cmd.ring_addr),
        .o_rdata(w_rd)
    );

    // shared multiplier: entry squares, then the pieces of the sum squared
    assign w_rd_mag = w_rd[C_X_W-1] ? C_MAG_W'(-w_rd) : w_rd;
    assign w_smag   = r_s[C_S_W-1] ? -r_s : r_s;
    assign w_lo     = w_smag[C_HALF_W-1:0];
    assign w_hi     = C_HALF_W'(w_smag >> C_HALF_W);

    always_comb begin
        if (i_cmd.sqr_mul) begin
            w_mul_a = (i_cmd.part == C_PART_LL) ? C_MUL_W'(w_lo) : C_MUL_W'(w_hi);
            w_mul_b = (i_cmd.part == C_PART_HH) ? C_MUL_W'(w_hi) : C_MUL_W'(w_lo);
        end else begin
            w_mul_a = w_rd_mag;
            w_mul_b = w_rd_mag;
        end
    end

    assign w_prod = w_mul_a * w_mul_b;

    always_comb begin
        case (i_cmd.part)
            C_PART_LL: w_part = C_D_W'(r_prod);
            C_PART_HL: w_part = C_D_W'(r_prod) << (C_HALF_W + 1);
            C_PART_HH: w_part = C_D_W'(r_prod) << (2 * C_HALF_W);
            default:   w_part = '0;
        endcase
    end

    // variance numerator and z numerator
    assign w_nq  = C_D_W'(r_q) * C_D_W'(C_WINDOW);
    assign w_d   = w_nq - r_s2;
    assign w_xe  = {{(C_NUM_W - C_X_W){r_x[C_X_W-1]}}, r_x};
    assign w_se  = {{(C_NUM_W - C_S_W){r_s[C_S_W-1]}}, r_s};
    assign w_num = w_xe * C_NUM_W'(C_WINDOW) - w_se;

    // one root bit per step
    assign w_rsh   = {r_rem, r_d[C_D_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_rdiff = w_rsh - w_trial;
    assign w_rge   = (w_rsh >= w_trial);

    // one quotient bit per step
    assign w_dsh   = {r_dr, r_dvd[C_DVD_W-1]};
    assign w_ddiff = w_dsh - {1'b0, r_root};
    assign w_dge   = (w_dsh >= {1'b0, r_root});

    // classification
    assign w_gt_enter = (r_dvd > C_DVD_W'(r_enter));
    assign w_lt_exit  = (r_dvd < C_DVD_W'(r_exit));
    assign w_pos_sat  = (r_dvd > C_DVD_W'(C_Z_POS_MAX));
    assign w_neg_sat  = (r_dvd > C_DVD_W'(C_Z_NEG_MAX));
    assign w_zneg     = w_neg_sat ? C_Z_W'(C_Z_NEG_MAX) : r_dvd[C_Z_W-1:0];

    always_comb begin
        if (i_cmd.warm) begin
            w_code = SIG_WARM;
            w_z    = '0;
            w_zsat = 1'b0;
        end else if (r_flat) begin
            w_code = SIG_FLAT;
            w_z    = '0;
            w_zsat = 1'b0;
        end else begin
            if (w_gt_enter) begin
                w_code = r_neg ? SIG_BELOW : SIG_ABOVE;
            end else if (w_lt_exit) begin
                w_code = SIG_CLOSE;
            end else begin
                w_code = SIG_HOLD;
            end
            if (r_neg) begin
                w_z    = -w_zneg;
                w_zsat = w_neg_sat;
            end else begin
                w_z    = w_pos_sat ? C_Z_W'(C_Z_POS_MAX) : r_dvd[C_Z_W-1:0];
                w_zsat = w_pos_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enter <= C_CFG_W'(C_ENTER_RST);
            r_exit  <= C_CFG_W'(C_EXIT_RST);
        end else if (i_cfg_write) begin
            if (i_cfg_index == C_REG_ENTER) begin
                r_enter <= i_cfg_data;
            end
            if (i_cfg_index == C_REG_EXIT) begin
                r_exit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x <= {1'b0, i_price_a} - {1'b0, i_price_b};
        end
        if (i_cmd.acc_clr) begin
            r_s  <= '0;
            r_q  <= '0;
            r_s2 <= '0;
        end
        if (i_cmd.sq_step) begin
            r_s <= r_s + {{(C_S_W - C_X_W){w_rd[C_X_W-1]}}, w_rd};
        end
        if (i_cmd.sq_step || i_cmd.sqr_mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.acc_step) begin
            r_q <= r_q + C_Q_W'(r_prod);
        end
        if (i_cmd.sqr_acc) begin
            r_s2 <= r_s2 + w_part;
        end
        if (i_cmd.diff) begin
            r_d    <= w_d;
            r_flat <= (w_d == '0);
            r_neg  <= w_num[C_NUM_W-1];
            r_nmag <= w_num[C_NUM_W-1] ? -w_num : w_num;
            r_root <= '0;
            r_rem  <= '0;
        end
        if (i_cmd.root_step) begin
            r_d    <= r_d << 2;
            r_rem  <= w_rge ? C_REM_W'(w_rdiff) : C_REM_W'(w_rsh);
            r_root <= {r_root[C_ROOT_W-2:0], w_rge};
        end
        if (i_cmd.div_init) begin
            r_dvd <= (C_DVD_W'(r_nmag) << C_FRAC) + C_DVD_W'(r_root >> 1);
            r_dr  <= '0;
        end
        if (i_cmd.div_step) begin
            r_dr  <= w_dge ? C_ROOT_W'(w_ddiff) : C_ROOT_W'(w_dsh);
            r_dvd <= {r_dvd[C_DVD_W-2:0], w_dge};
        end
        if (i_cmd.out_load) begin
            r_code <= w_code;
            r_z    <= w_z;
            r_zsat <= w_zsat;
        end
    end

    assign o_sts.flat    = r_flat;
    assign o_signal_code = r_code;
    assign o_z_value     = r_z;
    assign o_z_saturated = r_zsat;

endmodule

// ===== hdl/rzs_ctrl.sv =====
module rzs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  rzs_pkg::t_sts i_sts,
    output rzs_pkg::t_cmd o_cmd
);
    import rzs_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_RD    = 12'b0000_0000_0010,
        ST_SQ    = 12'b0000_0000_0100,
        ST_ACC   = 12'b0000_0000_1000,
        ST_SQR   = 12'b0000_0001_0000,
        ST_SQA   = 12'b0000_0010_0000,
        ST_DIFF  = 12'b0000_0100_0000,
        ST_CHK   = 12'b0000_1000_0000,
        ST_ROOT  = 12'b0001_0000_0000,
        ST_DINIT = 12'b0010_0000_0000,
        ST_DIV   = 12'b0100_0000_0000,
        ST_DONE  = 12'b1000_0000_0000
    } t_state;

    t_state              r_state, n_state;
    logic [C_CNT_W-1:0]  r_cnt, n_cnt;
    logic [C_PTR_W-1:0]  r_slot, n_slot;
    logic [C_FILL_W-1:0] r_fill, n_fill;
    logic                r_warm, n_warm;
    logic                r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_slot      = r_slot;
        n_fill      = r_fill;
        n_warm      = r_warm;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_warm        = (r_fill < C_FILL_W'(C_WINDOW));
                    if (r_fill < C_FILL_W'(C_WINDOW)) begin
                        n_state = ST_DONE;
                    end else begin
                        o_cmd.acc_clr = 1'b1;
                        n_cnt         = '0;
                        n_state       = ST_RD;
                    end
                end
            end
            ST_RD: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.ring_addr = r_cnt[C_PTR_W-1:0];
                n_state         = ST_SQ;
            end
            ST_SQ: begin
                o_cmd.sq_step = 1'b1;
                n_state       = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc_step = 1'b1;
                if (r_cnt == C_CNT_W'(C_WINDOW - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_SQR;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = ST_RD;
                end
            end
            ST_SQR: begin
                o_cmd.sqr_mul = 1'b1;
                o_cmd.part    = r_cnt[1:0];
                n_state       = ST_SQA;
            end
            ST_SQA: begin
                o_cmd.sqr_acc = 1'b1;
                o_cmd.part    = r_cnt[1:0];
                if (r_cnt[1:0] == C_PART_HH) begin
                    n_state = ST_DIFF;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = ST_SQR;
                end
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = ST_CHK;
            end
            ST_CHK: begin
                n_cnt   = '0;
                n_state = i_sts.flat ? ST_DONE : ST_ROOT;
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (r_cnt == C_CNT_W'(C_ROOT_W - 1)) begin
                    n_state = ST_DINIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == C_CNT_W'(C_DVD_W - 1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.ring_we   = 1'b1;
                    o_cmd.ring_addr = r_slot;
                    o_cmd.out_load  = 1'b1;
                    o_cmd.warm      = r_warm;
                    n_out_valid     = 1'b1;
                    n_slot          = (r_slot == C_PTR_W'(C_WINDOW - 1)) ? '0
                                                                         : r_slot + 1'b1;
                    if (r_warm) begin
                        n_fill = r_fill + 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_slot      <= '0;
            r_fill      <= '0;
            r_warm      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_slot      <= n_slot;
            r_fill      <= n_fill;
            r_warm      <= n_warm;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/rolling_zscore_threshold_signal.sv =====
// rolling z-score signal on the spread of two unsigned Q16.16 prices. each request
// gives exactly one result. the first 8 requests only fill the spread ring and return
// code 0 (warming). afterwards a request walks the ring one entry at a time
// through the single-port read and the shared 33x33 multiplier (read, square,
// accumulate), squares the window sum in three pieces, then a 36-step square
// root and a 54-step restoring divider each produce one bit per cycle. a flat
// window (zero variance) skips root and divider and returns code 5. one request
// is worked on at a time; the result sits in an output register, so the next
// request is taken as soon as the previous result has been loaded there. the user
// must write thresholds through the config port (index 0 entry, index 1 exit, both
// unsigned Q8.16) only while the block is idle; the block itself does not enforce it.
module rolling_zscore_threshold_signal (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input request channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [rzs_pkg::C_PRICE_W-1:0]        i_price_a,
    input  logic [rzs_pkg::C_PRICE_W-1:0]        i_price_b,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [rzs_pkg::C_CODE_W-1:0]         o_signal_code,
    output logic signed [rzs_pkg::C_Z_W-1:0]     o_z_value,
    output logic                                 o_z_saturated,
    // config write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rzs_pkg::C_CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rzs_pkg::C_CFG_W-1:0]          i_cfg_data
);
    import rzs_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    // sequencer: ring walk, sum squaring, root and divide loops
    rzs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // arithmetic, ring memory, thresholds and result register
    rzs_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_price_a    (i_price_a),
        .i_price_b    (i_price_b),
        .i_cfg_write  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_signal_code(o_signal_code),
        .o_z_value    (o_z_value),
        .o_z_saturated(o_z_saturated)
    );

`ifndef SYNTH
    // warming and flat results carry no z-score
    a_quiet_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_signal_code == SIG_WARM || o_signal_code == SIG_FLAT)
        |-> (o_z_value == '0) && !o_z_saturated)
        else $error("warming or flat result with nonzero z");

    // a clipped z-score sits at one of the range ends
    a_sat_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_z_saturated
        |-> (o_z_value == C_Z_W'(C_Z_POS_MAX)) || (o_z_value == C_Z_W'(C_Z_NEG_MAX)))
        else $error("saturated z not at range end");

    // one request in flight: an accepted request closes the input
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input reopened right after accept");
`endif

endmodule
